@@ sv/ecmp_path_selector_assert.svh @@
// Assertion macros shared by the path selector modules.
`ifndef ECMP_PATH_SELECTOR_ASSERT_SVH
`define ECMP_PATH_SELECTOR_ASSERT_SVH
`ifndef SYNTH
`define EPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define EPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define EPS_ASSERT(label, prop, msg)
`define EPS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ sv/eps_pkg.sv @@
// Types and constants of the ECMP path selector.
package eps_pkg;
   localparam int MAX_PATHS = 64;
   localparam int CNT_W = 7;
   localparam int IDX_W = 6;

   localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2 = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
   localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;
   localparam logic [31:0] KEY_BYTES = 32'd12;

   localparam logic [7:0] PROTO_TCP = 8'h06;
   localparam logic [7:0] PROTO_UDP = 8'h11;
   localparam logic [7:0] PROTO_ACK = 8'hFC;
   localparam logic [7:0] PROTO_NACK = 8'hFD;

   localparam int MID_DEPTH = 4;
   localparam int MID_PTR_W = 2;
   localparam int OUT_DEPTH = 16;
   localparam int OUT_PTR_W = 4;
   localparam int PIPE_DEPTH = 12;
   localparam int MOD_STAGES = 4;
   localparam int MOD_FIRST = PIPE_DEPTH - MOD_STAGES;

   typedef struct packed {
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [CNT_W-1:0] count;
   } key_type;

   typedef struct packed {
      logic route_found;
      logic [IDX_W-1:0] path_index;
   } result_type;
endpackage

@@ sv/eps_front.sv @@
// Front end: builds the hash key, clamps the path count and queues the word.
module eps_front import eps_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [31:0] req_source_addr,
   input  logic [31:0] req_dest_addr,
   input  logic [7:0] req_protocol,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [CNT_W-1:0] req_path_count,
   output logic key_valid,
   output key_type key_word,
   input  logic key_take
);
`include "ecmp_path_selector_assert.svh"

   key_type mid_ff [MID_DEPTH];
   logic [MID_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [MID_PTR_W:0] count_ff, count_in;
   logic push_fire;
   logic uses_ports;
   key_type key_in;

   always_comb begin
      unique case (req_protocol)
         PROTO_TCP, PROTO_UDP, PROTO_ACK, PROTO_NACK: uses_ports = 1'b1;
         default: uses_ports = 1'b0;
      endcase
      key_in.w0 = req_source_addr;
      key_in.w1 = req_dest_addr;
      key_in.w2 = uses_ports ? {req_dest_port, req_source_port} : 32'd0;
      if (req_path_count > CNT_W'(MAX_PATHS)) begin
         key_in.count = CNT_W'(MAX_PATHS);
      end else begin
         key_in.count = req_path_count;
      end
   end

   assign full = (count_ff == (MID_PTR_W+1)'(MID_DEPTH));
   assign push_fire = push && !full;
   assign key_valid = (count_ff != '0);
   assign key_word = mid_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + MID_PTR_W'(push_fire);
      rd_ptr_in = rd_ptr_ff + MID_PTR_W'(key_take);
      count_in = count_ff + (MID_PTR_W+1)'(push_fire) - (MID_PTR_W+1)'(key_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         mid_ff[wr_ptr_ff] <= key_in;
      end
   end

   `EPS_ASSERT_ALWAYS(a_mid_reset, reset |=> count_ff == '0, "Key queue not empty after reset.")
   `EPS_ASSERT(a_mid_bound, count_ff <= (MID_PTR_W+1)'(MID_DEPTH), "Key queue overfilled.")
   `EPS_ASSERT(a_take_nonempty, key_take |-> key_valid, "Word taken from an empty queue.")
endmodule

@@ sv/eps_out_queue.sv @@
// Result queue that holds finished words until the consumer pops them.
module eps_out_queue import eps_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic res_valid,
   input  result_type res_word,
   output logic empty,
   input  logic pop,
   output logic rsp_route_found,
   output logic [IDX_W-1:0] rsp_path_index
);
`include "ecmp_path_selector_assert.svh"

   result_type q_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OUT_PTR_W:0] count_ff, count_in;
   logic pop_fire;

   assign empty = (count_ff == '0);
   assign pop_fire = pop && !empty;
   assign rsp_route_found = q_ff[rd_ptr_ff].route_found;
   assign rsp_path_index = q_ff[rd_ptr_ff].path_index;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUT_PTR_W'(res_valid);
      rd_ptr_in = rd_ptr_ff + OUT_PTR_W'(pop_fire);
      count_in = count_ff + (OUT_PTR_W+1)'(res_valid) - (OUT_PTR_W+1)'(pop_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         q_ff[wr_ptr_ff] <= res_word;
      end
   end

   `EPS_ASSERT(a_no_overrun, res_valid |-> (count_ff != (OUT_PTR_W+1)'(OUT_DEPTH)) || pop_fire, "Result queue overrun.")
endmodule

@@ sv/eps_back.sv @@
// Back end: pipelined MurmurHash3 of the key followed by a pipelined modulo.
module eps_back import eps_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [31:0] seed,
   input  logic key_valid,
   input  key_type key_word,
   output logic key_take,
   input  logic res_popped,
   output logic res_valid,
   output result_type res_word
);
`include "ecmp_path_selector_assert.svh"

   function automatic logic [31:0] mix_h(input logic [31:0] h, input logic [31:0] k);
      logic [31:0] t;
      t = h ^ k;
      t = {t[18:0], t[31:19]};
      return (t << 2) + t + MIX_ADD;
   endfunction

   function automatic logic [CNT_W-1:0] mod_step8(input logic [CNT_W-1:0] r_start,
                                                  input logic [7:0] bits,
                                                  input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      r = r_start;
      for (int i = 7; i >= 0; i--) begin
         r = {r[CNT_W-2:0], bits[i]};
         if (r >= c) begin
            r = r - c;
         end
      end
      return r;
   endfunction

   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [CNT_W-1:0] cnt_ff [PIPE_DEPTH];
   logic [31:0] k1_ff [3];
   logic [31:0] k2_ff [3];
   logic [31:0] k3_ff [2];
   logic [31:0] k4_ff;
   logic [31:0] h3_ff, h4_ff, h5_ff, f6_ff, f7_ff, hash8_ff;
   logic [31:0] mh_ff [MOD_STAGES-1];
   logic [CNT_W-1:0] rem_ff [MOD_STAGES];
   logic [OUT_PTR_W:0] outstanding_ff, outstanding_in;
   logic [31:0] m0, m1, m2, f6_x, f6_y, f7_x;
   logic [CNT_W-1:0] last_cnt;

   assign key_take = key_valid && (outstanding_ff < (OUT_PTR_W+1)'(OUT_DEPTH));
   assign outstanding_in = outstanding_ff + (OUT_PTR_W+1)'(key_take)
                           - (OUT_PTR_W+1)'(res_popped);

   always_comb begin
      m0 = key_word.w0 * MIX_C1;
      m1 = key_word.w1 * MIX_C1;
      m2 = key_word.w2 * MIX_C1;
      f6_x = h5_ff ^ KEY_BYTES;
      f6_y = f6_x ^ (f6_x >> 16);
      f7_x = f6_ff ^ (f6_ff >> 13);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         outstanding_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], key_take};
         outstanding_ff <= outstanding_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff[0] <= key_word.count;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         cnt_ff[i] <= cnt_ff[i-1];
      end
      k1_ff[0] <= {m0[16:0], m0[31:17]};
      k1_ff[1] <= {m1[16:0], m1[31:17]};
      k1_ff[2] <= {m2[16:0], m2[31:17]};
      for (int i = 0; i < 3; i++) begin
         k2_ff[i] <= k1_ff[i] * MIX_C2;
      end
      h3_ff <= mix_h(seed, k2_ff[0]);
      k3_ff[0] <= k2_ff[1];
      k3_ff[1] <= k2_ff[2];
      h4_ff <= mix_h(h3_ff, k3_ff[0]);
      k4_ff <= k3_ff[1];
      h5_ff <= mix_h(h4_ff, k4_ff);
      f6_ff <= f6_y * FIN_C1;
      f7_ff <= f7_x * FIN_C2;
      hash8_ff <= f7_ff ^ (f7_ff >> 16);
      mh_ff[0] <= hash8_ff;
      rem_ff[0] <= mod_step8('0, hash8_ff[31:24], cnt_ff[MOD_FIRST-1]);
      mh_ff[1] <= mh_ff[0];
      rem_ff[1] <= mod_step8(rem_ff[0], mh_ff[0][23:16], cnt_ff[MOD_FIRST]);
      mh_ff[2] <= mh_ff[1];
      rem_ff[2] <= mod_step8(rem_ff[1], mh_ff[1][15:8], cnt_ff[MOD_FIRST+1]);
      rem_ff[3] <= mod_step8(rem_ff[2], mh_ff[2][7:0], cnt_ff[MOD_FIRST+2]);
   end

   assign last_cnt = cnt_ff[PIPE_DEPTH-1];
   assign res_valid = vld_ff[PIPE_DEPTH-1];
   assign res_word.route_found = (last_cnt != '0);
   assign res_word.path_index = (last_cnt != '0) ? rem_ff[MOD_STAGES-1][IDX_W-1:0] : '0;

   `EPS_ASSERT(a_credit_bound, outstanding_ff <= (OUT_PTR_W+1)'(OUT_DEPTH), "Too many words out.")
   `EPS_ASSERT(a_result_owed, res_valid |-> outstanding_ff != '0, "Result with no outstanding word.")
   `EPS_ASSERT(a_rem_range, (res_valid && last_cnt != '0) |-> rem_ff[MOD_STAGES-1] < last_cnt, "Remainder not below path count.")
endmodule

@@ sv/ecmp_path_selector.sv @@
// ECMP path selector: flow hash modulo path count, one word per cycle while the result queue has room.
// Throughput: one word per cycle while the result queue has room, set by the 12-stage hash and modulo pipeline.
// A 4-entry key queue and a 16-entry result queue let each side stall on its own.
// Reset is synchronous and active high: it empties both queues and clears the seed to 0.
module ecmp_path_selector import eps_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [31:0] req_source_addr,
   input  logic [31:0] req_dest_addr,
   input  logic [7:0] req_protocol,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [CNT_W-1:0] req_path_count,
   output logic empty,
   input  logic pop,
   output logic rsp_route_found,
   output logic [IDX_W-1:0] rsp_path_index,
   input  logic csr_write_en,
   input  logic [31:0] csr_write_data
);

   logic [31:0] hash_seed_ff;
   logic key_valid, key_take, res_valid;
   key_type key_word;
   result_type res_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff <= '0;
      end else if (csr_write_en) begin
         hash_seed_ff <= csr_write_data;
      end
   end

   eps_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_source_addr(req_source_addr),
      .req_dest_addr(req_dest_addr),
      .req_protocol(req_protocol),
      .req_source_port(req_source_port),
      .req_dest_port(req_dest_port),
      .req_path_count(req_path_count),
      .key_valid(key_valid),
      .key_word(key_word),
      .key_take(key_take)
   );

   eps_back u_back (
      .clock(clock),
      .reset(reset),
      .seed(hash_seed_ff),
      .key_valid(key_valid),
      .key_word(key_word),
      .key_take(key_take),
      .res_popped(pop && !empty),
      .res_valid(res_valid),
      .res_word(res_word)
   );

   eps_out_queue u_out_queue (
      .clock(clock),
      .reset(reset),
      .res_valid(res_valid),
      .res_word(res_word),
      .empty(empty),
      .pop(pop),
      .rsp_route_found(rsp_route_found),
      .rsp_path_index(rsp_path_index)
   );
endmodule

@@ bench/testbench.sv @@
// Testbench of the ECMP path selector: directed and random flow keys checked against a hash model.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import eps_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int RANDOM_WORDS = 300;
   localparam int HOLD_AT = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [31:0] HASH_M1 = 32'hcc9e2d51;
   localparam logic [31:0] HASH_M2 = 32'h1b873593;
   localparam logic [31:0] HASH_ADD = 32'he6546b64;
   localparam logic [31:0] HASH_F1 = 32'h85ebca6b;
   localparam logic [31:0] HASH_F2 = 32'hc2b2ae35;
   localparam logic [31:0] HASH_LEN = 32'd12;

   typedef struct {
      logic [31:0] source_addr;
      logic [31:0] dest_addr;
      logic [7:0] protocol;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [CNT_W-1:0] path_count;
   } flow_key_type;

   class path_scoreboard;
      result_type expected_paths[$];
      logic [31:0] seed = '0;
      int mismatches = 0;

      static function logic [31:0] rotate_left(logic [31:0] v, int r);
         return (v << r) | (v >> (32 - r));
      endfunction

      static function logic [31:0] mix_word(logic [31:0] h, logic [31:0] k);
         k = k * HASH_M1;
         k = rotate_left(k, 15);
         k = k * HASH_M2;
         h = h ^ k;
         h = rotate_left(h, 13);
         h = h * 32'd5 + HASH_ADD;
         return h;
      endfunction

      function logic [31:0] flow_hash(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
         logic [31:0] h;
         h = mix_word(seed, w0);
         h = mix_word(h, w1);
         h = mix_word(h, w2);
         h = h ^ HASH_LEN;
         h = h ^ (h >> 16);
         h = h * HASH_F1;
         h = h ^ (h >> 13);
         h = h * HASH_F2;
         h = h ^ (h >> 16);
         return h;
      endfunction

      function result_type choose_path(flow_key_type key);
         logic [31:0] ports;
         logic [31:0] count;
         logic [31:0] h;
         result_type r;
         ports = '0;
         if (key.protocol == PROTO_TCP || key.protocol == PROTO_UDP ||
             key.protocol == PROTO_ACK || key.protocol == PROTO_NACK) begin
            ports = {key.dest_port, key.source_port};
         end
         count = 32'(key.path_count);
         if (count > MAX_PATHS) begin
            count = MAX_PATHS;
         end
         r.route_found = 1'b0;
         r.path_index = '0;
         if (count != 0) begin
            h = flow_hash(key.source_addr, key.dest_addr, ports);
            r.route_found = 1'b1;
            r.path_index = IDX_W'(h % count);
         end
         return r;
      endfunction

      function void note_word(flow_key_type key);
         expected_paths = {expected_paths, choose_path(key)};
      endfunction

      function void check_word(logic found, logic [IDX_W-1:0] index);
         result_type want;
         if (expected_paths.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result word: route_found=%0b path_index=%0d", found, index);
            end
            return;
         end
         want = expected_paths.pop_front();
         if (found !== want.route_found) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("route_found mismatch: expected %0b, got %0b", want.route_found, found);
            end
         end
         if (index !== want.path_index) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("path_index mismatch: expected %0d, got %0d", want.path_index, index);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [31:0] req_source_addr = '0;
   logic [31:0] req_dest_addr = '0;
   logic [7:0] req_protocol = '0;
   logic [15:0] req_source_port = '0;
   logic [15:0] req_dest_port = '0;
   logic [CNT_W-1:0] req_path_count = '0;
   logic empty;
   logic pop = 1'b0;
   logic rsp_route_found;
   logic [IDX_W-1:0] rsp_path_index;
   logic csr_write_en = 1'b0;
   logic [31:0] csr_write_data = '0;

   path_scoreboard paths;
   int cycle_count = 0;
   int words_taken = 0;
   int send_burst = 0;

   ecmp_path_selector dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_source_addr(req_source_addr),
      .req_dest_addr(req_dest_addr),
      .req_protocol(req_protocol),
      .req_source_port(req_source_port),
      .req_dest_port(req_dest_port),
      .req_path_count(req_path_count),
      .empty(empty),
      .pop(pop),
      .rsp_route_found(rsp_route_found),
      .rsp_path_index(rsp_path_index),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 40) == 0) begin
         burst = $urandom_range(10, 40);
      end
      return $urandom_range(0, 5);
   endfunction

   function automatic logic [7:0] random_protocol();
      case ($urandom_range(0, 9))
         0: return PROTO_TCP;
         1: return PROTO_UDP;
         2: return PROTO_ACK;
         3: return PROTO_NACK;
         4, 5: return PROTO_TCP;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] random_count();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return CNT_W'($urandom_range(MAX_PATHS + 1, (1 << CNT_W) - 1));
         2: return CNT_W'(MAX_PATHS);
         default: return CNT_W'($urandom_range(1, MAX_PATHS));
      endcase
   endfunction

   task automatic send_word(logic [31:0] src, logic [31:0] dst, logic [7:0] proto,
                            logic [15:0] sport, logic [15:0] dport, logic [CNT_W-1:0] count);
      flow_key_type key;
      int gap;
      key.source_addr = src;
      key.dest_addr = dst;
      key.protocol = proto;
      key.source_port = sport;
      key.dest_port = dport;
      key.path_count = count;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_source_addr <= src;
      req_dest_addr <= dst;
      req_protocol <= proto;
      req_source_port <= sport;
      req_dest_port <= dport;
      req_path_count <= count;
      do @(posedge clock); while (full);
      paths.note_word(key);
   endtask

   task automatic drain_results();
      push <= 1'b0;
      while (paths.expected_paths.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      paths.seed = value;
   endtask

   initial begin : take_results
      int gap;
      int burst;
      burst = 0;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(burst);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         paths.check_word(rsp_route_found, rsp_path_index);
         words_taken++;
         if (words_taken == HOLD_AT) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin : run_phases
      logic [31:0] seeds[4];
      paths = new;
      seeds[0] = 32'hFFFF_FFFF;
      seeds[1] = $urandom;
      seeds[2] = 32'h0000_0000;
      seeds[3] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first phase runs with the seed left by reset.
      send_word('0, '0, '0, '0, '0, '0);
      send_word('1, '1, PROTO_TCP, '1, '1, '0);
      send_word('1, '1, 8'hFF, '1, '1, '1);
      send_word('0, '0, PROTO_UDP, '0, '0, 7'd1);
      send_word(32'h0A00_0001, 32'h0A00_0002, PROTO_TCP, 16'd1234, 16'd80, 7'd64);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, PROTO_UDP, 16'hFFFF, 16'h0000, 7'd65);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, PROTO_ACK, 16'h0000, 16'hFFFF, 7'd63);
      send_word(32'hC0A8_0101, 32'hC0A8_0202, PROTO_NACK, 16'h8000, 16'h0001, 7'd2);
      send_word(32'hC0A8_0101, 32'hC0A8_0202, 8'h00, 16'hFFFF, 16'hFFFF, 7'd64);
      send_word(32'hC0A8_0101, 32'hC0A8_0202, 8'h07, 16'h1111, 16'h2222, 7'd33);
      send_word(32'hC0A8_0101, 32'hC0A8_0202, 8'h05, 16'h1111, 16'h2222, 7'd17);
      send_word(32'h1234_5678, 32'h9ABC_DEF0, 8'hFE, 16'h0050, 16'h01BB, 7'd3);
      send_word(32'h1234_5678, 32'h9ABC_DEF0, 8'h10, 16'h0050, 16'h01BB, 7'd7);
      send_word(32'h1234_5678, 32'h9ABC_DEF0, 8'h12, 16'h0050, 16'h01BB, 7'd100);
      send_word(32'h1234_5678, 32'h9ABC_DEF0, PROTO_TCP, 16'h0050, 16'h01BB, 7'd64);
      send_word(32'h1234_5678, 32'h9ABC_DEF0, PROTO_TCP, 16'h01BB, 16'h0050, 7'd64);
      send_word('1, '0, PROTO_NACK, '1, '1, 7'd1);

      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            drain_results();
            write_seed(seeds[phase - 1]);
         end
         repeat (RANDOM_WORDS) begin
            send_word($urandom, $urandom, random_protocol(), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), random_count());
         end
      end

      drain_results();
      if (paths.mismatches == 0 && paths.expected_paths.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
